// ===== rtl/core/key_pool_level_monitor_unit_defines.svh =====
// Assertion macros for the key pool level monitor.
`ifndef KEY_POOL_LEVEL_MONITOR_UNIT_DEFINES_SVH
`define KEY_POOL_LEVEL_MONITOR_UNIT_DEFINES_SVH

// condition holds at every clock edge out of reset
`define KPLM_ASSERT_NOW(name, cond, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// consequence holds in the same cycle as the trigger
`define KPLM_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequence holds in the cycle after the trigger
`define KPLM_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/kplm_pkg.sv =====
// Shared constants, codes and types for the key pool level monitor.
package kplm_pkg;

    localparam int LVL_DEPTH = 16;
    localparam int IVL_DEPTH = 8;
    localparam int LVL_AW    = $clog2(LVL_DEPTH);
    localparam int LVL_CW    = $clog2(LVL_DEPTH + 1);
    localparam int IVL_AW    = $clog2(IVL_DEPTH);
    localparam int IVL_CW    = $clog2(IVL_DEPTH + 1);
    localparam int CNT_W     = (LVL_CW > IVL_CW) ? LVL_CW : IVL_CW;

    localparam int LEVEL_W   = 32;
    localparam int TIME_W    = 40;
    localparam int AVG_W     = 48;
    localparam int FRAC_W    = 8;
    localparam int HLIM_W    = 3;
    localparam int SUM_W     = TIME_W + IVL_AW;
    localparam int DVD_W     = SUM_W + FRAC_W;
    localparam int DIV_BITS  = 4;
    localparam int DIV_STEPS = (DVD_W + DIV_BITS - 1) / DIV_BITS;
    localparam int DVD_PW    = DIV_STEPS * DIV_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    localparam logic [LEVEL_W-1:0] MIN_LEVEL_RST = 32'd1000000;
    localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST = 32'd1000000000;
    localparam logic [LEVEL_W-1:0] THR_LEVEL_RST = 32'd2000000;
    localparam logic [LEVEL_W-1:0] LEVEL_RST     = 32'd5000000;
    localparam logic [HLIM_W-1:0]  HLIM_RST      = 3'd5;
    localparam logic [LVL_CW-1:0]  WIN_LEN_RST   = LVL_CW'(5);

    typedef enum logic [1:0] {
        REG_MIN_LEVEL     = 2'd0,
        REG_MAX_LEVEL     = 2'd1,
        REG_THRESHOLD     = 2'd2,
        REG_HISTORY_LIMIT = 2'd3
    } reg_idx_t;

    typedef enum logic {
        CMD_ADD     = 1'b0,
        CMD_CONSUME = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_EMPTY    = 2'd0,
        ST_WARNING  = 2'd1,
        ST_CHARGING = 2'd2,
        ST_READY    = 2'd3
    } pool_status_t;

    typedef struct packed {
        logic              start;
        logic [DVD_W-1:0]  dividend;
        logic [IVL_CW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DVD_PW-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== rtl/core/key_pool_level_monitor_unit.sv =====
// Top level of the key pool level monitor: sequencer, level and interval stores, APB registers.
// Each beat on s_ carries an add or consume command; one result beat on m_ follows.
// An add sums the stored charge intervals (up to 8) with one memory read per interval, then
// forms the mean interval in the divider, 4 quotient bits per cycle, logs the new interval,
// and compares the window levels (up to 15) with one memory read per level. With no
// interval stored an add skips the divider. An accepted consume goes straight to the
// window compare; a refused one goes straight to the result. s_ready is low while a beat
// is in work; a finished result is held in the output register, and the next beat can be
// taken while it waits. No clearing pass after reset.
`include "key_pool_level_monitor_unit_defines.svh"

module key_pool_level_monitor_unit
    import kplm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_command,
    input  logic [LEVEL_W-1:0]   s_amount,
    input  logic [TIME_W-1:0]    s_time_ms,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_accepted,
    output logic [LEVEL_W-1:0]   m_level,
    output logic [1:0]           m_pool_status,
    output logic                 m_status_changed,
    output logic                 m_rising,
    output logic [TIME_W-1:0]    m_last_charge_interval,
    output logic [AVG_W-1:0]     m_avg_charge_interval,

    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_SUM  = 8'b0000_0010,
        S_DIV  = 8'b0000_0100,
        S_LOG  = 8'b0000_1000,
        S_WIN  = 8'b0001_0000,
        S_SCAN = 8'b0010_0000,
        S_REC  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } state_t;

    state_t              state_reg, state_next;

    logic [LEVEL_W-1:0]  min_level_reg, max_level_reg, thr_level_reg;
    logic [HLIM_W-1:0]   hist_lim_reg;

    logic [LEVEL_W-1:0]  level_reg, level_next;
    pool_status_t        status_reg, status_next;
    pool_status_t        before_reg, before_next;
    logic                rising_reg, rising_next;
    logic                ok_reg, ok_next;
    logic [31:0]         entry_num_reg, entry_num_next;
    logic [31:0]         entry_last_reg, entry_last_next;
    logic [LVL_CW-1:0]   win_len_reg, win_len_next;
    logic [LVL_AW-1:0]   lvl_head_reg, lvl_head_next;
    logic [LVL_CW-1:0]   lvl_fill_reg, lvl_fill_next;
    logic [IVL_AW-1:0]   ivl_head_reg, ivl_head_next;
    logic [IVL_CW-1:0]   ivl_fill_reg, ivl_fill_next;
    logic [TIME_W-1:0]   last_time_reg, last_time_next;
    logic [TIME_W-1:0]   last_ivl_reg, last_ivl_next;
    logic [AVG_W-1:0]    avg_reg, avg_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                pend_reg, pend_next;
    logic                rise_reg, rise_next;
    logic [LVL_CW-1:0]   keep_reg, keep_next;
    logic                m_valid_reg, m_valid_next;

    logic [TIME_W-1:0]   time_reg, time_next;
    logic [SUM_W-1:0]    acc_reg, acc_next;

    logic [LEVEL_W-1:0]  lvl_mem [LVL_DEPTH];
    logic [TIME_W-1:0]   ivl_mem [IVL_DEPTH];
    logic [LEVEL_W-1:0]  lvl_rdata;
    logic [TIME_W-1:0]   ivl_rdata;
    logic [LVL_AW-1:0]   lvl_raddr, lvl_waddr;
    logic [IVL_AW-1:0]   ivl_raddr, ivl_waddr;
    logic                lvl_we, ivl_we;
    logic [TIME_W-1:0]   ivl_wdata;

    logic [LEVEL_W:0]    add_sum;
    logic [SUM_W-1:0]    acc_add;
    logic                hit;
    logic [31:0]         ikeep, span;
    logic [LVL_CW-1:0]   lkeep;
    pool_status_t        st_new;
    logic                out_load;

    div_req_t            div_req;
    div_rsp_t            div_rsp;

    kplm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // APB registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_level_reg <= MIN_LEVEL_RST;
            max_level_reg <= MAX_LEVEL_RST;
            thr_level_reg <= THR_LEVEL_RST;
            hist_lim_reg  <= HLIM_RST;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx_t'(paddr[PADDR_W-1:2]))
                REG_MIN_LEVEL:     min_level_reg <= pwdata[LEVEL_W-1:0];
                REG_MAX_LEVEL:     max_level_reg <= pwdata[LEVEL_W-1:0];
                REG_THRESHOLD:     thr_level_reg <= pwdata[LEVEL_W-1:0];
                REG_HISTORY_LIMIT: hist_lim_reg  <= pwdata[HLIM_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx_t'(paddr[PADDR_W-1:2]))
            REG_MIN_LEVEL:     prdata = PDATA_W'(min_level_reg);
            REG_MAX_LEVEL:     prdata = PDATA_W'(max_level_reg);
            REG_THRESHOLD:     prdata = PDATA_W'(thr_level_reg);
            REG_HISTORY_LIMIT: prdata = PDATA_W'(hist_lim_reg);
        endcase
    end

    assign pready = 1'b1;

    // level window and interval log, both newest-first rings
    always_ff @(posedge aclk) begin
        if (lvl_we) begin
            lvl_mem[lvl_waddr] <= level_reg;
        end
        lvl_rdata <= lvl_mem[lvl_raddr];
    end

    always_ff @(posedge aclk) begin
        if (ivl_we) begin
            ivl_mem[ivl_waddr] <= ivl_wdata;
        end
        ivl_rdata <= ivl_mem[ivl_raddr];
    end

    assign add_sum   = {1'b0, level_reg} + {1'b0, s_amount};
    assign acc_add   = acc_reg + (pend_reg ? SUM_W'(ivl_rdata) : SUM_W'(0));
    assign hit       = pend_reg && (lvl_rdata > level_reg);
    assign lvl_raddr = lvl_head_reg + cnt_reg[LVL_AW-1:0];
    assign ivl_raddr = ivl_head_reg + cnt_reg[IVL_AW-1:0];
    assign lvl_waddr = lvl_head_reg - 1'b1;
    assign ivl_waddr = ivl_head_reg - 1'b1;
    assign ivl_wdata = time_reg - last_time_reg;
    assign span      = entry_num_reg - entry_last_reg;

    always_comb begin
        ikeep = 32'(ivl_fill_reg);
        if (32'(hist_lim_reg) < ikeep) begin
            ikeep = 32'(hist_lim_reg);
        end
        if (32'(IVL_DEPTH - 1) < ikeep) begin
            ikeep = 32'(IVL_DEPTH - 1);
        end
    end

    always_comb begin
        lkeep = lvl_fill_reg;
        if (win_len_reg < lkeep) begin
            lkeep = win_len_reg;
        end
        if (LVL_CW'(LVL_DEPTH - 1) < lkeep) begin
            lkeep = LVL_CW'(LVL_DEPTH - 1);
        end
    end

    // status with hysteresis
    always_comb begin
        priority if (level_reg >= thr_level_reg) begin
            st_new = ST_READY;
        end else if (level_reg > min_level_reg
                     && ((rise_reg && status_reg != ST_READY) || status_reg == ST_EMPTY)) begin
            st_new = ST_CHARGING;
        end else if (level_reg > min_level_reg && status_reg != ST_CHARGING) begin
            st_new = ST_WARNING;
        end else if (level_reg <= min_level_reg) begin
            st_new = ST_EMPTY;
        end else begin
            st_new = status_reg;
        end
    end

    always_comb begin
        state_next      = state_reg;
        level_next      = level_reg;
        status_next     = status_reg;
        before_next     = before_reg;
        rising_next     = rising_reg;
        ok_next         = ok_reg;
        entry_num_next  = entry_num_reg;
        entry_last_next = entry_last_reg;
        win_len_next    = win_len_reg;
        lvl_head_next   = lvl_head_reg;
        lvl_fill_next   = lvl_fill_reg;
        ivl_head_next   = ivl_head_reg;
        ivl_fill_next   = ivl_fill_reg;
        last_time_next  = last_time_reg;
        last_ivl_next   = last_ivl_reg;
        avg_next        = avg_reg;
        cnt_next        = cnt_reg;
        pend_next       = pend_reg;
        rise_next       = rise_reg;
        keep_next       = keep_reg;
        time_next       = time_reg;
        acc_next        = acc_reg;
        lvl_we          = 1'b0;
        ivl_we          = 1'b0;
        out_load        = 1'b0;
        m_valid_next    = m_valid_reg && !m_ready;
        div_req.start    = 1'b0;
        div_req.dividend = {acc_add, FRAC_W'(0)};
        div_req.divisor  = ivl_fill_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    before_next = status_reg;
                    time_next   = s_time_ms;
                    cnt_next    = '0;
                    pend_next   = 1'b0;
                    acc_next    = '0;
                    if (s_command == CMD_ADD) begin
                        ok_next = add_sum < {1'b0, max_level_reg};
                        if (add_sum < {1'b0, max_level_reg}) begin
                            level_next = add_sum[LEVEL_W-1:0];
                        end
                        state_next = S_SUM;
                    end else if (level_reg > s_amount) begin
                        ok_next    = 1'b1;
                        level_next = level_reg - s_amount;
                        state_next = S_WIN;
                    end else begin
                        ok_next    = 1'b0;
                        state_next = S_DONE;
                    end
                end
            end
            S_SUM: begin
                acc_next = acc_add;
                if (cnt_reg < CNT_W'(ivl_fill_reg)) begin
                    cnt_next  = cnt_reg + 1'b1;
                    pend_next = 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (ivl_fill_reg == '0) begin
                        avg_next   = '0;
                        state_next = S_LOG;
                    end else begin
                        div_req.start = 1'b1;
                        state_next    = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    avg_next   = div_rsp.quotient[AVG_W-1:0];
                    state_next = S_LOG;
                end
            end
            S_LOG: begin
                ivl_we          = 1'b1;
                last_ivl_next   = ivl_wdata;
                ivl_head_next   = ivl_waddr;
                ivl_fill_next   = IVL_CW'(ikeep) + 1'b1;
                last_time_next  = time_reg;
                entry_last_next = entry_num_reg;
                if (span > 32'(LVL_DEPTH - 1)) begin
                    win_len_next = LVL_CW'(LVL_DEPTH - 1);
                end else begin
                    win_len_next = span[LVL_CW-1:0];
                end
                state_next = S_WIN;
            end
            S_WIN: begin
                keep_next  = lkeep;
                cnt_next   = '0;
                pend_next  = 1'b0;
                rise_next  = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN: begin
                rise_next = rise_reg && !hit;
                if (cnt_reg < CNT_W'(keep_reg)) begin
                    cnt_next  = cnt_reg + 1'b1;
                    pend_next = 1'b1;
                end else begin
                    pend_next  = 1'b0;
                    state_next = S_REC;
                end
            end
            S_REC: begin
                lvl_we         = 1'b1;
                lvl_head_next  = lvl_waddr;
                lvl_fill_next  = keep_reg + 1'b1;
                rising_next    = rise_reg;
                status_next    = st_new;
                entry_num_next = entry_num_reg + 1'b1;
                state_next     = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            level_reg      <= LEVEL_RST;
            status_reg     <= ST_EMPTY;
            before_reg     <= ST_EMPTY;
            rising_reg     <= 1'b0;
            ok_reg         <= 1'b0;
            entry_num_reg  <= '0;
            entry_last_reg <= '0;
            win_len_reg    <= WIN_LEN_RST;
            lvl_head_reg   <= '0;
            lvl_fill_reg   <= '0;
            ivl_head_reg   <= '0;
            ivl_fill_reg   <= '0;
            last_time_reg  <= '0;
            last_ivl_reg   <= '0;
            avg_reg        <= '0;
            cnt_reg        <= '0;
            pend_reg       <= 1'b0;
            rise_reg       <= 1'b0;
            keep_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            level_reg      <= level_next;
            status_reg     <= status_next;
            before_reg     <= before_next;
            rising_reg     <= rising_next;
            ok_reg         <= ok_next;
            entry_num_reg  <= entry_num_next;
            entry_last_reg <= entry_last_next;
            win_len_reg    <= win_len_next;
            lvl_head_reg   <= lvl_head_next;
            lvl_fill_reg   <= lvl_fill_next;
            ivl_head_reg   <= ivl_head_next;
            ivl_fill_reg   <= ivl_fill_next;
            last_time_reg  <= last_time_next;
            last_ivl_reg   <= last_ivl_next;
            avg_reg        <= avg_next;
            cnt_reg        <= cnt_next;
            pend_reg       <= pend_next;
            rise_reg       <= rise_next;
            keep_reg       <= keep_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        time_reg <= time_next;
        acc_reg  <= acc_next;
        if (out_load) begin
            m_accepted             <= ok_reg;
            m_level                <= level_reg;
            m_pool_status          <= status_reg;
            m_status_changed       <= (status_reg != before_reg);
            m_rising               <= rising_reg;
            m_last_charge_interval <= last_ivl_reg;
            m_avg_charge_interval  <= avg_reg;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    `KPLM_ASSERT_NEXT(a_one_beat_in_work, s_valid && s_ready, !s_ready, "second beat taken while busy")
    `KPLM_ASSERT_IMP(a_div_done_in_div, div_rsp.done, state_reg == S_DIV, "divider result outside wait")
    `KPLM_ASSERT_NOW(a_store_bounds, (lvl_fill_reg <= LVL_CW'(LVL_DEPTH)) && (ivl_fill_reg <= IVL_CW'(IVL_DEPTH)) && (win_len_reg < LVL_CW'(LVL_DEPTH)), "store fill out of range")

endmodule

// ===== rtl/core/kplm_div.sv =====
// Iterative restoring divider, four quotient bits per cycle, small divisor.
module kplm_div
    import kplm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_PW-1:0]    quo_reg, quo_next;
    logic [IVL_CW-1:0]    rem_reg, rem_next;
    logic [IVL_CW-1:0]    dsr_reg, dsr_next;
    logic [DVD_PW-1:0]    q_step;
    logic [IVL_CW-1:0]    r_step;
    logic [IVL_CW:0]      trial;

    always_comb begin
        q_step = quo_reg;
        r_step = rem_reg;
        trial  = '0;
        for (int i = 0; i < DIV_BITS; i++) begin
            trial  = {r_step, q_step[DVD_PW-1]};
            q_step = {q_step[DVD_PW-2:0], 1'b0};
            if (trial >= {1'b0, dsr_reg}) begin
                trial     = trial - {1'b0, dsr_reg};
                q_step[0] = 1'b1;
            end
            r_step = trial[IVL_CW-1:0];
        end
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_STEPS - 1);
            quo_next  = DVD_PW'(req.dividend);
            rem_next  = '0;
            dsr_next  = req.divisor;
        end else if (busy_reg) begin
            quo_next = q_step;
            rem_next = r_step;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule
